>>> src/pointer_dead_zone_ema_width_assert.svh
// Assertion macros shared by the pointer smoother modules.
`ifndef POINTER_DEAD_ZONE_EMA_WIDTH_ASSERT_SVH
`define POINTER_DEAD_ZONE_EMA_WIDTH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PDZ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pointer smoother: implication check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PDZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pointer smoother: next-cycle check failed");

`endif

>>> src/pdz_pkg.sv
// Shared types, codes and constants of the pointer smoother.
package pdz_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOOL_KIND        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ERASER_WIDTH     = 3'd7;

  // Event kinds
  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_MOVE    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Register reset values
  localparam logic [8:0]  RST_SMOOTHING_WEIGHT = 9'd128;
  localparam logic [11:0] RST_DEAD_ZONE        = 12'd16;
  localparam logic [11:0] RST_BASE_WIDTH       = 12'd48;
  localparam logic [11:0] RST_WIDTH_STEP       = 12'd8;
  localparam logic [11:0] RST_MIN_WIDTH        = 12'd16;
  localparam logic        RST_DYNAMIC_WIDTH    = 1'b1;
  localparam logic        RST_TOOL_KIND        = 1'b0;
  localparam logic [11:0] RST_ERASER_WIDTH     = 12'd320;

  // Arithmetic constants
  localparam logic [8:0]  WEIGHT_ONE       = 9'd256;
  localparam logic [32:0] ROUND_HALF       = 33'd128;
  localparam logic signed [13:0] HALF_PIXEL_WIDTH = 14'sd8;
  localparam logic signed [13:0] MAX_WIDTH        = 14'sd4095;

  typedef struct packed {
    logic [8:0]  smoothing_weight;
    logic [11:0] dead_zone;
    logic [11:0] base_width;
    logic [11:0] width_step;
    logic [11:0] min_width;
    logic        dynamic_width;
    logic        tool_kind;
    logic [11:0] eraser_width;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIST_DY,
    ST_DZ_SQ,
    ST_CHECK,
    ST_BLEND_XA,
    ST_BLEND_XB,
    ST_BLEND_YA,
    ST_BLEND_YB,
    ST_SPEED_X,
    ST_SPEED_Y,
    ST_SPEED_SUM,
    ST_WIDTH,
    ST_EMIT
  } state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_DX,
    MUL_DY,
    MUL_DZ,
    MUL_W_RX,
    MUL_V_SX,
    MUL_W_RY,
    MUL_V_SY
  } mul_sel_t;

  // Accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ROUND,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     latch_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     set_x;
    logic     set_y;
    logic     do_press;
    logic     do_release;
    logic     upd_width;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       pen_down;
    logic       near;
  } dp_status_t;

endpackage

>>> src/pointer_dead_zone_ema_width.sv
// Top level of the pointer smoother with dead zone, moving average and dynamic width.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------------
//   in      | in_valid / in_ready   | mode, x_pos, y_pos
//   out     | out_valid / out_ready | point_x, point_y, stroke_width, stroke_start
//   cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One item at a time through a sequencer over one shared 16x16 multiplier.
// A move runs the decode, distance, dead-zone, blend, speed and width steps (nine useful
// products through the multiplier), loads its result and takes the next item in the
// cycle after the load; a press skips to emit, the rest end at decode or the check.
// A result still waiting in the output register holds the emit step.
// The output register holds a result while the next item is taken and worked.
// Synchronous reset clears stroke state and loads the register defaults.
module pointer_dead_zone_ema_width (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [15:0]                   x_pos,
  input  logic [15:0]                   y_pos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   point_x,
  output logic [15:0]                   point_y,
  output logic [11:0]                   stroke_width,
  output logic                          stroke_start,
  input  logic                          cfg_we,
  input  logic [pdz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data
);

  pdz_pkg::cfg_t       cfg;
  pdz_pkg::ctrl_cmd_t  cmd;
  pdz_pkg::dp_status_t status;

  pdz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pdz_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .point_x      (point_x),
    .point_y      (point_y),
    .stroke_width (stroke_width),
    .stroke_start (stroke_start)
  );

endmodule

>>> src/pdz_cfg.sv
// Configuration register file of the pointer smoother.
module pdz_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pdz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data,
  output pdz_pkg::cfg_t                 cfg
);

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_weight <= pdz_pkg::RST_SMOOTHING_WEIGHT;
      cfg.dead_zone        <= pdz_pkg::RST_DEAD_ZONE;
      cfg.base_width       <= pdz_pkg::RST_BASE_WIDTH;
      cfg.width_step       <= pdz_pkg::RST_WIDTH_STEP;
      cfg.min_width        <= pdz_pkg::RST_MIN_WIDTH;
      cfg.dynamic_width    <= pdz_pkg::RST_DYNAMIC_WIDTH;
      cfg.tool_kind        <= pdz_pkg::RST_TOOL_KIND;
      cfg.eraser_width     <= pdz_pkg::RST_ERASER_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdz_pkg::REG_SMOOTHING_WEIGHT: cfg.smoothing_weight <= cfg_data[8:0];
        pdz_pkg::REG_DEAD_ZONE:        cfg.dead_zone        <= cfg_data;
        pdz_pkg::REG_BASE_WIDTH:       cfg.base_width       <= cfg_data;
        pdz_pkg::REG_WIDTH_STEP:       cfg.width_step       <= cfg_data;
        pdz_pkg::REG_MIN_WIDTH:        cfg.min_width        <= cfg_data;
        pdz_pkg::REG_DYNAMIC_WIDTH:    cfg.dynamic_width    <= cfg_data[0];
        pdz_pkg::REG_TOOL_KIND:        cfg.tool_kind        <= cfg_data[0];
        pdz_pkg::REG_ERASER_WIDTH:     cfg.eraser_width     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/pdz_dp.sv
// Datapath of the pointer smoother: shared multiplier, accumulator, stroke state.
`include "pointer_dead_zone_ema_width_assert.svh"

module pdz_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  pdz_pkg::cfg_t          cfg,
  input  pdz_pkg::ctrl_cmd_t     cmd,
  output pdz_pkg::dp_status_t    status,
  input  logic [1:0]             mode,
  input  logic [15:0]            x_pos,
  input  logic [15:0]            y_pos,
  output logic [15:0]            point_x,
  output logic [15:0]            point_y,
  output logic [11:0]            stroke_width,
  output logic                   stroke_start
);

  logic [1:0]  in_mode;
  logic [15:0] raw_x;
  logic [15:0] raw_y;
  logic [15:0] smooth_x;
  logic [15:0] smooth_y;
  logic        pen_down;
  logic [32:0] last_speed_sq;
  logic signed [12:0] width_offset;
  logic signed [12:0] width_offset_next;
  logic [31:0] prod;
  logic [32:0] acc;

  logic [15:0] dx;
  logic [15:0] dy;
  logic [8:0]  w_eff;
  logic [8:0]  w_inv;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] prod_ext;

  logic signed [13:0] off_ext;
  logic signed [13:0] step_ext;
  logic signed [13:0] floor_off;
  logic signed [13:0] off_dn;
  logic signed [13:0] off_up;
  logic signed [13:0] wsum;
  logic [11:0]        width_dyn;
  logic [11:0]        width_sel;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_mode <= mode;
      raw_x   <= x_pos;
      raw_y   <= y_pos;
    end
  end

  // Distances to the smoothed point and clamped weights
  always_comb begin
    dx    = (raw_x >= smooth_x) ? raw_x - smooth_x : smooth_x - raw_x;
    dy    = (raw_y >= smooth_y) ? raw_y - smooth_y : smooth_y - raw_y;
    w_eff = (cfg.smoothing_weight > pdz_pkg::WEIGHT_ONE) ? pdz_pkg::WEIGHT_ONE
                                                         : cfg.smoothing_weight;
    w_inv = pdz_pkg::WEIGHT_ONE - w_eff;
  end

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      pdz_pkg::MUL_DX:   begin mul_a = dx;                mul_b = dx;            end
      pdz_pkg::MUL_DY:   begin mul_a = dy;                mul_b = dy;            end
      pdz_pkg::MUL_DZ:   begin
        mul_a = {4'b0, cfg.dead_zone};
        mul_b = {4'b0, cfg.dead_zone};
      end
      pdz_pkg::MUL_W_RX: begin mul_a = {7'b0, w_eff};     mul_b = raw_x;         end
      pdz_pkg::MUL_V_SX: begin mul_a = {7'b0, w_inv};     mul_b = smooth_x;      end
      pdz_pkg::MUL_W_RY: begin mul_a = {7'b0, w_eff};     mul_b = raw_y;         end
      pdz_pkg::MUL_V_SY: begin mul_a = {7'b0, w_inv};     mul_b = smooth_y;      end
      default:           begin mul_a = '0;                mul_b = '0;            end
    endcase
  end

  // Register the product, then accumulate it
  assign prod_ext = {1'b0, prod};

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      pdz_pkg::ACC_LOAD:  acc <= prod_ext;
      pdz_pkg::ACC_ROUND: acc <= prod_ext + pdz_pkg::ROUND_HALF;
      pdz_pkg::ACC_ADD:   acc <= acc + prod_ext;
      default:            acc <= acc;
    endcase
  end

  // Next width offset from the speed trend
  always_comb begin
    off_ext   = {width_offset[12], width_offset};
    step_ext  = $signed({2'b0, cfg.width_step});
    floor_off = $signed({2'b0, cfg.min_width}) - $signed({2'b0, cfg.base_width});
    off_dn    = off_ext - step_ext;
    off_up    = off_ext + step_ext;
    width_offset_next = width_offset;
    if (acc > last_speed_sq) begin
      width_offset_next = (off_dn < floor_off) ? floor_off[12:0] : off_dn[12:0];
    end else if (acc < last_speed_sq) begin
      width_offset_next = (off_up > 14'sd0) ? 13'sd0 : off_up[12:0];
    end
  end

  // Width of the emitted point
  always_comb begin
    wsum = $signed({2'b0, cfg.base_width}) + off_ext;
    if (wsum < pdz_pkg::HALF_PIXEL_WIDTH) begin
      width_dyn = pdz_pkg::HALF_PIXEL_WIDTH[11:0];
    end else if (wsum > pdz_pkg::MAX_WIDTH) begin
      width_dyn = pdz_pkg::MAX_WIDTH[11:0];
    end else begin
      width_dyn = wsum[11:0];
    end
    if (cfg.tool_kind) begin
      width_sel = cfg.eraser_width;
    end else if (!cfg.dynamic_width) begin
      width_sel = cfg.base_width;
    end else begin
      width_sel = width_dyn;
    end
  end

  // Pen state
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_down <= 1'b0;
    end else if (cmd.do_press) begin
      pen_down <= 1'b1;
    end else if (cmd.do_release) begin
      pen_down <= 1'b0;
    end
  end

  // Smoothed point, offset and last speed
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_x      <= '0;
      smooth_y      <= '0;
      last_speed_sq <= '0;
      width_offset  <= '0;
    end else if (cmd.do_press) begin
      smooth_x      <= raw_x;
      smooth_y      <= raw_y;
      last_speed_sq <= '0;
      width_offset  <= -$signed({1'b0, cfg.base_width});
    end else begin
      if (cmd.set_x) begin
        smooth_x <= acc[23:8];
      end
      if (cmd.set_y) begin
        smooth_y <= acc[23:8];
      end
      if (cmd.upd_width && cfg.dynamic_width) begin
        width_offset  <= width_offset_next;
        last_speed_sq <= acc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x      <= smooth_x;
      point_y      <= smooth_y;
      stroke_width <= width_sel;
      stroke_start <= (in_mode == pdz_pkg::MODE_PRESS);
    end
  end

  assign status.mode     = in_mode;
  assign status.pen_down = pen_down;
  assign status.near     = acc < prod_ext;

  `PDZ_ASSERT_IMPL(a_offset_range, 1'b1, !(width_offset[12] && (width_offset[11:0] == 12'd0)))
  `PDZ_ASSERT_NEXT(a_width_floor, cmd.load_out && cfg.dynamic_width && !cfg.tool_kind, stroke_width >= 12'd8)
  `PDZ_ASSERT_NEXT(a_press_seeds, cmd.do_press, pen_down && (last_speed_sq == 33'd0))

endmodule

>>> src/pdz_ctrl.sv
// Sequencer of the pointer smoother: handshakes and datapath commands.
`include "pointer_dead_zone_ema_width_assert.svh"

module pdz_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pdz_pkg::dp_status_t status,
  output pdz_pkg::ctrl_cmd_t  cmd
);

  pdz_pkg::state_t state;
  pdz_pkg::state_t state_next;
  logic            out_valid_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = pdz_pkg::MUL_DX;
    cmd.acc_op     = pdz_pkg::ACC_HOLD;
    unique case (state)
      pdz_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_next   = pdz_pkg::ST_DECODE;
        end
      end
      pdz_pkg::ST_DECODE: begin
        // start the raw-to-smoothed distance while deciding
        cmd.mul_sel = pdz_pkg::MUL_DX;
        unique case (status.mode)
          pdz_pkg::MODE_PRESS: begin
            cmd.do_press = 1'b1;
            state_next   = pdz_pkg::ST_EMIT;
          end
          pdz_pkg::MODE_MOVE: begin
            state_next = status.pen_down ? pdz_pkg::ST_DIST_DY : pdz_pkg::ST_IDLE;
          end
          pdz_pkg::MODE_RELEASE: begin
            cmd.do_release = 1'b1;
            state_next     = pdz_pkg::ST_IDLE;
          end
          default: state_next = pdz_pkg::ST_IDLE;
        endcase
      end
      pdz_pkg::ST_DIST_DY: begin
        cmd.acc_op  = pdz_pkg::ACC_LOAD;
        cmd.mul_sel = pdz_pkg::MUL_DY;
        state_next  = pdz_pkg::ST_DZ_SQ;
      end
      pdz_pkg::ST_DZ_SQ: begin
        cmd.acc_op  = pdz_pkg::ACC_ADD;
        cmd.mul_sel = pdz_pkg::MUL_DZ;
        state_next  = pdz_pkg::ST_CHECK;
      end
      pdz_pkg::ST_CHECK: begin
        // drop the move inside the dead zone
        cmd.mul_sel = pdz_pkg::MUL_W_RX;
        state_next  = status.near ? pdz_pkg::ST_IDLE : pdz_pkg::ST_BLEND_XA;
      end
      pdz_pkg::ST_BLEND_XA: begin
        cmd.acc_op  = pdz_pkg::ACC_ROUND;
        cmd.mul_sel = pdz_pkg::MUL_V_SX;
        state_next  = pdz_pkg::ST_BLEND_XB;
      end
      pdz_pkg::ST_BLEND_XB: begin
        cmd.acc_op  = pdz_pkg::ACC_ADD;
        cmd.mul_sel = pdz_pkg::MUL_W_RY;
        state_next  = pdz_pkg::ST_BLEND_YA;
      end
      pdz_pkg::ST_BLEND_YA: begin
        cmd.set_x   = 1'b1;
        cmd.acc_op  = pdz_pkg::ACC_ROUND;
        cmd.mul_sel = pdz_pkg::MUL_V_SY;
        state_next  = pdz_pkg::ST_BLEND_YB;
      end
      pdz_pkg::ST_BLEND_YB: begin
        cmd.acc_op = pdz_pkg::ACC_ADD;
        state_next = pdz_pkg::ST_SPEED_X;
      end
      pdz_pkg::ST_SPEED_X: begin
        cmd.set_y   = 1'b1;
        cmd.mul_sel = pdz_pkg::MUL_DX;
        state_next  = pdz_pkg::ST_SPEED_Y;
      end
      pdz_pkg::ST_SPEED_Y: begin
        cmd.acc_op  = pdz_pkg::ACC_LOAD;
        cmd.mul_sel = pdz_pkg::MUL_DY;
        state_next  = pdz_pkg::ST_SPEED_SUM;
      end
      pdz_pkg::ST_SPEED_SUM: begin
        cmd.acc_op = pdz_pkg::ACC_ADD;
        state_next = pdz_pkg::ST_WIDTH;
      end
      pdz_pkg::ST_WIDTH: begin
        cmd.upd_width = 1'b1;
        state_next    = pdz_pkg::ST_EMIT;
      end
      pdz_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = pdz_pkg::ST_IDLE;
        end
      end
      default: state_next = pdz_pkg::ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Take no item while reset is held
  assign in_ready = (state == pdz_pkg::ST_IDLE) && !rst;

  `PDZ_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  `PDZ_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `PDZ_ASSERT_IMPL(a_result_from_emit, $rose(out_valid), $past(state) == pdz_pkg::ST_EMIT)

endmodule
